### rtl/assert_macros.svh
// assertion macros used by the port checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define LDDN_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lddn assertion failed");

// next-cycle implication, sampled on the rising clock, off during reset
`define LDDN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lddn assertion failed");

`endif

### rtl/lddn_pkg.sv
// package: lunar year table, month boundary builder and shared types
package lddn_pkg;

    localparam int NumYears     = 12;
    localparam int TableRows    = 12;
    localparam int UsedRows     = (NumYears < TableRows) ? NumYears : TableRows;
    localparam int LastDay      = 4409;
    localparam int BigLen       = 30;
    localparam int SmallLen     = 29;
    // twelve months, one leap month, two spare small months for year overrun
    localparam int SlotsPerYear = 15;
    localparam int NumSlots     = UsedRows * SlotsPerYear;

    localparam int DayW    = 13;
    localparam int MonthW  = 4;
    localparam int LDayW   = 5;

    typedef struct packed {
        logic              valid;
        logic [DayW-1:0]   start;
        logic [MonthW-1:0] month;
    } t_slot;

    typedef struct packed {
        logic              found;
        logic [DayW-1:0]   start;
        logic [MonthW-1:0] month;
    } t_sel;

    // new-year day of each table row
    function automatic logic [DayW-1:0] ny_day(input int row);
        logic [DayW-1:0] v;
        case (row)
            0:       v = DayW'(39);
            1:       v = DayW'(393);
            2:       v = DayW'(778);
            3:       v = DayW'(1132);
            4:       v = DayW'(1486);
            5:       v = DayW'(1870);
            6:       v = DayW'(2224);
            7:       v = DayW'(2578);
            8:       v = DayW'(2962);
            9:       v = DayW'(3317);
            10:      v = DayW'(3701);
            11:      v = DayW'(4055);
            default: v = '0;
        endcase
        return v;
    endfunction

    // bit m-1 set: month m has 30 days
    function automatic logic [11:0] big_mask(input int row);
        logic [11:0] v;
        case (row)
            0:       v = 12'h56A;
            1:       v = 12'hB55;
            2:       v = 12'hBA4;
            3:       v = 12'hB49;
            4:       v = 12'hD53;
            5:       v = 12'hA95;
            6:       v = 12'h52D;
            7:       v = 12'h55D;
            8:       v = 12'hAB5;
            9:       v = 12'hBAA;
            10:      v = 12'h5D2;
            11:      v = 12'hDA5;
            default: v = '0;
        endcase
        return v;
    endfunction

    // leap month number, zero for none
    function automatic logic [MonthW-1:0] leap_month(input int row);
        logic [MonthW-1:0] v;
        case (row)
            1:       v = MonthW'(7);
            4:       v = MonthW'(5);
            7:       v = MonthW'(4);
            9:       v = MonthW'(9);
            default: v = '0;
        endcase
        return v;
    endfunction

    // start day and month number of one month slot, evaluated at elaboration;
    // a slot reaching the next new year or LastDay + 1 is invalid, starts there
    function automatic t_slot slot_info(input int idx);
        int          row;
        int          k;
        int          start;
        int          month;
        int          len;
        int          bound;
        int          lm;
        bit          in_leap;
        bit          leap_done;
        logic [11:0] mask;
        t_slot       s;
        row       = idx / SlotsPerYear;
        k         = idx % SlotsPerYear;
        mask      = big_mask(row);
        lm        = int'(leap_month(row));
        start     = int'(ny_day(row));
        month     = 1;
        in_leap   = 1'b0;
        leap_done = 1'b0;
        for (int j = 0; j < k; j++) begin
            if (in_leap) begin
                len = SmallLen;
            end else if (month <= 12 && mask[month-1]) begin
                len = BigLen;
            end else begin
                len = SmallLen;
            end
            start = start + len;
            if (in_leap) begin
                in_leap = 1'b0;
                month   = month + 1;
            end else if (!leap_done && lm != 0 && lm == month) begin
                in_leap   = 1'b1;
                leap_done = 1'b1;
            end else begin
                month = month + 1;
            end
        end
        bound   = (row < UsedRows - 1) ? int'(ny_day(row + 1)) : LastDay + 1;
        s.valid = (start < bound);
        s.start = s.valid ? DayW'(start) : DayW'(bound);
        s.month = MonthW'(month);
        return s;
    endfunction

endpackage

### rtl/lddn_slot_sel.sv
// month slot finder: compares a day against every month start of the table
module lddn_slot_sel (
    input  logic [lddn_pkg::DayW-1:0] i_day,
    output lddn_pkg::t_sel            o_sel
);
    import lddn_pkg::*;

    logic [NumSlots-1:0] w_ge;
    logic [NumSlots-1:0] w_hit;
    logic [DayW-1:0]     w_start_term [NumSlots];
    logic [MonthW-1:0]   w_month_term [NumSlots];

    for (genvar i = 0; i < NumSlots; i++) begin : g_slot
        localparam t_slot Slot = slot_info(i);
        assign w_ge[i] = (i_day >= Slot.start);
        // starts never drop by index, so the last slot reached is a single edge
        if (i < NumSlots - 1) begin : g_mid
            assign w_hit[i] = w_ge[i] & ~w_ge[i+1] & Slot.valid;
        end else begin : g_last
            assign w_hit[i] = w_ge[i] & Slot.valid;
        end
        assign w_start_term[i] = w_hit[i] ? Slot.start : '0;
        assign w_month_term[i] = w_hit[i] ? Slot.month : '0;
    end

    always_comb begin
        o_sel.found = w_ge[0];
        o_sel.start = '0;
        o_sel.month = '0;
        for (int i = 0; i < NumSlots; i++) begin
            o_sel.start = o_sel.start | w_start_term[i];
            o_sel.month = o_sel.month | w_month_term[i];
        end
    end

endmodule

### rtl/lunar_date_from_day_number.sv
// top level: day number to lunar month and day converter
// pipeline: input register stage, then result register stage
// throughput: one item per cycle while the result channel is not stalled
// reset: i_rst_n synchronous active low, clears both valid flags only
// no table clearing pass, the year table is constant logic
module lunar_date_from_day_number (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [lddn_pkg::DayW-1:0]   i_day_number,
    // result channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [lddn_pkg::MonthW-1:0] o_lunar_month,
    output logic [lddn_pkg::LDayW-1:0]  o_lunar_day
);
    import lddn_pkg::*;

    // input register stage
    logic              r_in_valid;
    logic              n_in_valid;
    logic [DayW-1:0]   r_day;

    // result register stage
    logic              r_out_valid;
    logic              n_out_valid;
    logic [MonthW-1:0] r_month;
    logic [MonthW-1:0] n_month;
    logic [LDayW-1:0]  r_lday;
    logic [LDayW-1:0]  n_lday;

    logic              w_out_free;
    logic              w_advance;
    logic              w_accept;
    logic [DayW-1:0]   w_day_sat;
    logic [DayW-1:0]   w_offset;
    t_sel              w_sel;

    // result slot empties or drains this cycle
    assign w_out_free = !r_out_valid || !i_stall;
    // input stage moves into the result stage
    assign w_advance  = r_in_valid && w_out_free;
    // input stage holds only when its item cannot move on
    assign o_stall    = r_in_valid && !w_out_free;
    assign w_accept   = i_valid && !o_stall;

    // days past the last covered lunar day are pinned to it
    assign w_day_sat = (r_day > DayW'(LastDay)) ? DayW'(LastDay) : r_day;

    lddn_slot_sel u_slot_sel (
        .i_day (w_day_sat),
        .o_sel (w_sel)
    );

    // day within the month, counted from one; wraps to the 5-bit field
    assign w_offset = w_day_sat - w_sel.start + DayW'(1);

    always_comb begin
        n_in_valid  = r_in_valid;
        n_out_valid = r_out_valid;
        if (w_advance) begin
            n_in_valid = 1'b0;
        end
        if (w_accept) begin
            n_in_valid = 1'b1;
        end
        if (w_out_free) begin
            n_out_valid = w_advance;
        end
        // days before the first new year read as the first day of month one
        if (w_sel.found) begin
            n_month = w_sel.month;
            n_lday  = w_offset[LDayW-1:0];
        end else begin
            n_month = MonthW'(1);
            n_lday  = LDayW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers load on a handshake, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_day <= i_day_number;
        end
        if (w_advance) begin
            r_month <= n_month;
            r_lday  <= n_lday;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_lunar_month = r_month;
    assign o_lunar_day   = r_lday;

endmodule

### rtl/lddn_checker.sv
// port checker for the lunar date converter and its bind
`include "assert_macros.svh"

module lddn_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [lddn_pkg::MonthW-1:0] o_lunar_month,
    input logic [lddn_pkg::LDayW-1:0]  o_lunar_day
);
    import lddn_pkg::*;

    // a held result keeps its fields
    `LDDN_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_lunar_month) && $stable(o_lunar_day))

    // upstream sees back-pressure only behind a full, stalled result slot
    `LDDN_ASSERT_SAME(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall)

    // an accepted item reaches the output when the result slot is not stalled
    `LDDN_ASSERT_NEXT(a_latency, i_clk, i_rst_n, (i_valid && !o_stall) ##1 !i_stall, o_valid)

    // results never carry a zero month or a day outside one to thirty
    `LDDN_ASSERT_SAME(a_range, i_clk, i_rst_n, o_valid, o_lunar_month != '0 && o_lunar_day != '0 && o_lunar_day <= LDayW'(BigLen))

endmodule

bind lunar_date_from_day_number lddn_checker u_lddn_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_lunar_month (o_lunar_month),
    .o_lunar_day   (o_lunar_day)
);

### test/lunar_date_checker.sv
// checker: watches both channels, predicts lunar dates and compares results
`timescale 1ns / 100ps

module lunar_date_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic [lddn_pkg::DayW-1:0]   i_day_number,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [lddn_pkg::MonthW-1:0] i_lunar_month,
    input  logic [lddn_pkg::LDayW-1:0]  i_lunar_day,
    output int                          o_fail_count,
    output int                          o_pending
);
    import lddn_pkg::*;

    localparam int MaxReports = 10;

    // lunar new year of 2005..2016 as day numbers, row 0 on the right
    localparam logic [11:0][DayW-1:0] NewYearDay = {
        13'd4055, 13'd3701, 13'd3317, 13'd2962, 13'd2578, 13'd2224,
        13'd1870, 13'd1486, 13'd1132, 13'd778,  13'd393,  13'd39
    };
    // bit m-1 set: month m has thirty days
    localparam logic [11:0][11:0] BigMonths = {
        12'hDA5, 12'h5D2, 12'hBAA, 12'hAB5, 12'h55D, 12'h52D,
        12'hA95, 12'hD53, 12'hB49, 12'hBA4, 12'hB55, 12'h56A
    };
    // month followed by a leap month, zero when the year has none
    localparam logic [11:0][MonthW-1:0] LeapBase = {
        4'd0, 4'd0, 4'd9, 4'd0, 4'd4, 4'd0, 4'd0, 4'd5, 4'd0, 4'd0, 4'd7, 4'd0
    };

    typedef struct packed {
        logic [DayW-1:0]   day_number;
        logic [MonthW-1:0] month;
        logic [LDayW-1:0]  day;
    } t_lunar_date;

    t_lunar_date pending_dates[$];
    int          report_count;

    function automatic t_lunar_date lunar_of_day(input logic [DayW-1:0] dn);
        int          d;
        int          row;
        int          rem;
        int          mon;
        int          len;
        bit          found;
        bit          in_leap;
        bit          leap_done;
        logic [11:0] mask;
        t_lunar_date r;
        d     = int'(dn);
        found = 1'b0;
        row   = 0;
        r.day_number = dn;
        if (d > LastDay) begin
            d = LastDay;
        end
        for (int i = UsedRows - 1; i >= 0; i--) begin
            if (!found && d >= int'(NewYearDay[i])) begin
                row   = i;
                found = 1'b1;
            end
        end
        if (!found) begin
            r.month = MonthW'(1);
            r.day   = LDayW'(1);
            return r;
        end
        rem       = d - int'(NewYearDay[row]);
        mask      = BigMonths[row];
        mon       = 1;
        in_leap   = 1'b0;
        leap_done = 1'b0;
        forever begin
            if (in_leap) begin
                len = SmallLen;
            end else if (mon <= 12 && mask[mon-1]) begin
                len = BigLen;
            end else begin
                len = SmallLen;
            end
            if (rem < len) begin
                break;
            end
            rem = rem - len;
            if (in_leap) begin
                in_leap = 1'b0;
                mon     = mon + 1;
            end else if (!leap_done && LeapBase[row] != 0 && int'(LeapBase[row]) == mon) begin
                in_leap   = 1'b1;
                leap_done = 1'b1;
            end else begin
                mon = mon + 1;
            end
        end
        r.month = MonthW'(mon);
        r.day   = LDayW'(rem + 1);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_lunar_date want;
        if (!i_rst_n) begin
            o_fail_count = 0;
            o_pending    = 0;
            report_count = 0;
            pending_dates.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_dates.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    if (report_count < MaxReports) begin
                        $display("unexpected result %0d/%0d at %0t",
                                 i_lunar_month, i_lunar_day, $realtime);
                    end
                    report_count = report_count + 1;
                end else begin
                    want = pending_dates.pop_front();
                    if (i_lunar_month !== want.month || i_lunar_day !== want.day) begin
                        o_fail_count = o_fail_count + 1;
                        if (report_count < MaxReports) begin
                            $display("mismatch day %0d: expected %0d/%0d got %0d/%0d",
                                     want.day_number, want.month, want.day,
                                     i_lunar_month, i_lunar_day);
                        end
                        report_count = report_count + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pending_dates.push_back(lunar_of_day(i_day_number));
            end
            o_pending = pending_dates.size();
        end
    end

endmodule

### test/tb_lunar_date_from_day_number.sv
// testbench top: clock, reset, item stimulus, result stalls and verdict
`timescale 1ns / 100ps

module tb_lunar_date_from_day_number;
    import lddn_pkg::*;

    // cycles with no item moving on either channel before the run is abandoned
    localparam int IdleLimit   = 2000;
    localparam int LongHold    = 40;
    localparam int RandomItems = 1800;
    localparam int QuietItems  = 200;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [DayW-1:0]   i_day_number;
    logic              o_valid;
    logic              i_stall;
    logic [MonthW-1:0] o_lunar_month;
    logic [LDayW-1:0]  o_lunar_day;

    int fail_count;
    int pending;
    int idle_cycles;

    // sender asks for the long hold, receiver reports it done
    bit hold_request;
    bit hold_done;
    bit quiet;

    lunar_date_from_day_number dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_day_number  (i_day_number),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_lunar_month (o_lunar_month),
        .o_lunar_day   (o_lunar_day)
    );

    lunar_date_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_day_number  (i_day_number),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_lunar_month (o_lunar_month),
        .i_lunar_day   (o_lunar_day),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // drive one item at a falling edge and hold it until the block takes it
    task automatic offer_day(input logic [DayW-1:0] d);
        i_valid      <= 1'b1;
        i_day_number <= d;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // random day: mostly inside the table, some near a new year,
    // some before the first new year, some anywhere in the 13-bit field
    function automatic logic [DayW-1:0] pick_day();
        int sel;
        int d;
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
            d = $urandom_range(0, LastDay);
        end else if (sel == 7) begin
            d = int'(ny_day($urandom_range(0, UsedRows - 1))) + $urandom_range(0, 6) - 3;
        end else if (sel == 8) begin
            d = $urandom_range(0, 60);
        end else begin
            d = $urandom_range(0, (1 << DayW) - 1);
        end
        return DayW'(d);
    endfunction

    // sender: directed days, a fill against a long result stall, a drain,
    // then random days with idle bursts and a final stretch with none
    initial begin
        logic [DayW-1:0] directed_days[$];
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_day_number = '0;
        hold_request = 1'b0;
        quiet        = 1'b0;
        // extremes, the first new year, the short 2006 row (day 777 runs into
        // month 13), leap months of 2006 and 2009, last covered day, saturation
        directed_days = '{13'd0, 13'd1, 13'd38, 13'd39, 13'd40, 13'd392, 13'd393,
                          13'd600, 13'd615, 13'd640, 13'd776, 13'd777, 13'd778,
                          13'd1600, 13'd1640, 13'd3316, 13'd3317, 13'd4055,
                          13'd4408, 13'd4409, 13'd4410, 13'h0AAA, 13'h1555,
                          13'h1000, 13'h1FFF};
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_days[k]) begin
            offer_day(directed_days[k]);
        end

        // keep offering while the receiver holds off, so the block backs up
        hold_request = 1'b1;
        while (!hold_done) begin
            offer_day(pick_day());
        end

        // pause until every result is back
        i_valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (pending != 0);

        for (int n = 0; n < RandomItems; n++) begin
            if (n == RandomItems - QuietItems) begin
                quiet = 1'b1;
            end
            if (!quiet && $urandom_range(0, 3) == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge i_clk);
            end
            offer_day(pick_day());
        end

        // drain, then wait on for any stray result
        i_valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (pending != 0);
        repeat (8) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("lunar_date_from_day_number regression: pass");
        end else begin
            $display("lunar_date_from_day_number regression: fail");
        end
        $finish;
    end

    // receiver: random stall bursts and free runs, one long hold on request
    initial begin
        i_stall   = 1'b0;
        hold_done = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_request && !hold_done) begin
                i_stall <= 1'b1;
                repeat (LongHold) @(negedge i_clk);
                hold_done = 1'b1;
            end else if (quiet) begin
                i_stall <= 1'b0;
                @(negedge i_clk);
            end else if ($urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(negedge i_clk);
            end else begin
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
        end
    end

    // watchdog: any cycle that moves an item resets the count
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
            end
            if (idle_cycles >= IdleLimit) begin
                break;
            end
        end
        $display("lunar_date_from_day_number regression: fail");
        $finish;
    end

endmodule
